// ===== design/tpsp_pkg.sv =====
`timescale 1ns / 1ps

package tpsp_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int DUTY_FULL_DEF   = 1000;

   localparam int ANGLE_W    = 16;
   localparam int AMP_W      = 16;
   localparam int LEVEL_W    = 16;
   localparam int DUTY_W     = 11;
   localparam int TURN_W     = ANGLE_W + 1;
   localparam int NUM_PHASES = 3;

   typedef logic [TURN_W-1:0] turn_type;
   typedef logic [LEVEL_W-1:0] level_type;

   localparam turn_type THIRD_TURN     = 17'd21845;
   localparam turn_type TWO_THIRD_TURN = 17'd43691;

   localparam turn_type PHASE_OFFSET [NUM_PHASES] = '{17'd0, THIRD_TURN, TWO_THIRD_TURN};
   localparam logic     PHASE_STEP   [NUM_PHASES] = '{1'b0, 1'b1, 1'b1};

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef struct packed {
      logic idx_en;
      logic rom_en;
      logic mul_en;
      logic out_en;
   } stage_en_type;

   // Offset sine entry, (1 + sin)/2 * full duty, from a Q32 phase of the turn.
   function automatic level_type sine_rom_entry(input logic [63:0] ph,
                                                input logic [63:0] duty_full);
      logic [1:0]  q;
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] v;
      logic [63:0] scaled;
      q = ph[31:30];
      r = ph & (Q30_ONE - 64'd1);
      if (q[0]) begin
         r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = Q30_ONE - x2 / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      v = q[1] ? (Q30_ONE - s) : (Q30_ONE + s);
      scaled = (v * duty_full) >> 31;
      return scaled[LEVEL_W-1:0];
   endfunction

endpackage

// ===== design/tpsp_req_if.sv =====
`timescale 1ns / 1ps

interface tpsp_req_if;
   logic                           valid;
   logic                           ready;
   logic [tpsp_pkg::ANGLE_W-1:0]   angle;
   logic [tpsp_pkg::AMP_W-1:0]     amplitude;

   modport source (output valid, output angle, output amplitude, input ready);
   modport sink   (input valid, input angle, input amplitude, output ready);
endinterface

// ===== design/tpsp_rsp_if.sv =====
`timescale 1ns / 1ps

interface tpsp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tpsp_pkg::DUTY_W-1:0]   duty_a;
   logic [tpsp_pkg::DUTY_W-1:0]   duty_b;
   logic [tpsp_pkg::DUTY_W-1:0]   duty_c;

   modport source (output valid, output duty_a, output duty_b, output duty_c, input ready);
   modport sink   (input valid, input duty_a, input duty_b, input duty_c, output ready);
endinterface

// ===== design/three_phase_sine_pwm_unit.sv =====
`timescale 1ns / 1ps

// Three-phase sine PWM compare generator. Each request beat carries an electrical angle
// (65536 is one turn) and an amplitude in unsigned Q1.15; the response beat carries three
// compare values for phases A, B and C, one third of a turn apart, each the offset sine
// table entry scaled by the amplitude and saturated at twice the full duty. A new beat is
// taken every cycle unless a held response stalls the stages, and each result passes through
// the four-stage pipeline: index arithmetic, a registered read of the sine table with one
// port per phase, the amplitude multiply and the saturating output register. Stages only
// stall behind a held response, so bubbles are squeezed out. The table is fixed when the
// design is built, so there is no start-up pass after reset.
module three_phase_sine_pwm_unit #(
   parameter int TABLE_DEPTH = tpsp_pkg::TABLE_DEPTH_DEF,
   parameter int DUTY_FULL   = tpsp_pkg::DUTY_FULL_DEF
) (
   input  logic          clock,
   input  logic          reset,
   tpsp_req_if.sink      req_bus,
   tpsp_rsp_if.source    rsp_bus
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   tpsp_pkg::stage_en_type en;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic [tpsp_pkg::AMP_W-1:0] amp1_ff;
   logic [tpsp_pkg::AMP_W-1:0] amp2_ff;

   logic [tpsp_pkg::NUM_PHASES-1:0][IDX_W-1:0]             idx;
   logic [tpsp_pkg::NUM_PHASES-1:0][tpsp_pkg::LEVEL_W-1:0] level;
   logic [tpsp_pkg::NUM_PHASES-1:0][tpsp_pkg::DUTY_W-1:0]  duty;

   always_comb begin
      en.out_en = !v4_ff || rsp_bus.ready;
      en.mul_en = !v3_ff || en.out_en;
      en.rom_en = !v2_ff || en.mul_en;
      en.idx_en = !v1_ff || en.rom_en;
      v1_in = en.idx_en ? req_bus.valid : v1_ff;
      v2_in = en.rom_en ? v1_ff : v2_ff;
      v3_in = en.mul_en ? v2_ff : v3_ff;
      v4_in = en.out_en ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en.idx_en) begin
         amp1_ff <= req_bus.amplitude;
      end
      if (en.rom_en) begin
         amp2_ff <= amp1_ff;
      end
   end

   tpsp_index #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_index (
      .clock (clock),
      .en    (en),
      .angle (req_bus.angle),
      .idx   (idx)
   );

   tpsp_rom #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .DUTY_FULL   (DUTY_FULL)
   ) u_rom (
      .clock (clock),
      .en    (en),
      .idx   (idx),
      .level (level)
   );

   for (genvar g = 0; g < tpsp_pkg::NUM_PHASES; g++) begin : g_scale
      tpsp_scale #(
         .DUTY_FULL (DUTY_FULL)
      ) u_scale (
         .clock     (clock),
         .en        (en),
         .amplitude (amp2_ff),
         .level     (level[g]),
         .duty      (duty[g])
      );
   end

   assign req_bus.ready  = en.idx_en;
   assign rsp_bus.valid  = v4_ff;
   assign rsp_bus.duty_a = duty[0];
   assign rsp_bus.duty_b = duty[1];
   assign rsp_bus.duty_c = duty[2];

endmodule

// ===== design/tpsp_index.sv =====
`timescale 1ns / 1ps

module tpsp_index #(
   parameter int TABLE_DEPTH = tpsp_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                             clock,
   input  tpsp_pkg::stage_en_type                           en,
   input  logic [tpsp_pkg::ANGLE_W-1:0]                     angle,
   output logic [tpsp_pkg::NUM_PHASES-1:0][$clog2(TABLE_DEPTH)-1:0] idx
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int DW     = $clog2(TABLE_DEPTH + 1);
   localparam int PROD_W = tpsp_pkg::TURN_W + DW;
   localparam int POS_W  = DW + 1;

   logic [tpsp_pkg::NUM_PHASES-1:0][IDX_W-1:0] idx_ff;
   logic [tpsp_pkg::NUM_PHASES-1:0][IDX_W-1:0] idx_in;

   for (genvar g = 0; g < tpsp_pkg::NUM_PHASES; g++) begin : g_phase
      tpsp_pkg::turn_type  sum;
      logic [PROD_W-1:0]   prod;
      logic [POS_W-1:0]    pos;
      logic [POS_W-1:0]    stepped;
      logic [POS_W-1:0]    wrapped;

      always_comb begin
         sum     = tpsp_pkg::turn_type'(angle) + tpsp_pkg::PHASE_OFFSET[g];
         prod    = PROD_W'(sum) * PROD_W'(TABLE_DEPTH);
         pos     = prod[PROD_W-1:tpsp_pkg::ANGLE_W];
         stepped = pos + POS_W'(tpsp_pkg::PHASE_STEP[g]);
         if (stepped >= POS_W'(TABLE_DEPTH)) begin
            wrapped = stepped - POS_W'(TABLE_DEPTH);
         end else begin
            wrapped = stepped;
         end
         idx_in[g] = wrapped[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.idx_en) begin
         idx_ff <= idx_in;
      end
   end

   assign idx = idx_ff;

endmodule

// ===== design/tpsp_rom.sv =====
`timescale 1ns / 1ps

module tpsp_rom #(
   parameter int TABLE_DEPTH = tpsp_pkg::TABLE_DEPTH_DEF,
   parameter int DUTY_FULL   = tpsp_pkg::DUTY_FULL_DEF
) (
   input  logic                                                     clock,
   input  tpsp_pkg::stage_en_type                                   en,
   input  logic [tpsp_pkg::NUM_PHASES-1:0][$clog2(TABLE_DEPTH)-1:0] idx,
   output logic [tpsp_pkg::NUM_PHASES-1:0][tpsp_pkg::LEVEL_W-1:0]   level
);

   tpsp_pkg::level_type rom_tbl [TABLE_DEPTH];
   logic [tpsp_pkg::NUM_PHASES-1:0][tpsp_pkg::LEVEL_W-1:0] level_ff;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_entry
      localparam logic [63:0] Ph = (64'(g) << 32) / TABLE_DEPTH;
      assign rom_tbl[g] = tpsp_pkg::sine_rom_entry(Ph, 64'(DUTY_FULL));
   end

   for (genvar p = 0; p < tpsp_pkg::NUM_PHASES; p++) begin : g_port
      always_ff @(posedge clock) begin
         if (en.rom_en) begin
            level_ff[p] <= rom_tbl[idx[p]];
         end
      end
   end

   assign level = level_ff;

endmodule

// ===== design/tpsp_scale.sv =====
`timescale 1ns / 1ps

module tpsp_scale #(
   parameter int DUTY_FULL = tpsp_pkg::DUTY_FULL_DEF
) (
   input  logic                          clock,
   input  tpsp_pkg::stage_en_type        en,
   input  logic [tpsp_pkg::AMP_W-1:0]    amplitude,
   input  logic [tpsp_pkg::LEVEL_W-1:0]  level,
   output logic [tpsp_pkg::DUTY_W-1:0]   duty
);

   localparam int PROD_W   = tpsp_pkg::AMP_W + tpsp_pkg::LEVEL_W;
   localparam int SCALED_W = PROD_W - 15;
   localparam logic [SCALED_W-1:0] LIMIT = SCALED_W'(2 * DUTY_FULL);

   logic [PROD_W-1:0]          prod_ff;
   logic [PROD_W-1:0]          prod_in;
   logic [SCALED_W-1:0]        scaled;
   logic [tpsp_pkg::DUTY_W-1:0] duty_ff;
   logic [tpsp_pkg::DUTY_W-1:0] duty_in;

   always_comb begin
      prod_in = PROD_W'(amplitude) * PROD_W'(level);
      scaled  = prod_ff[PROD_W-1:15];
      if (scaled > LIMIT) begin
         duty_in = LIMIT[tpsp_pkg::DUTY_W-1:0];
      end else begin
         duty_in = scaled[tpsp_pkg::DUTY_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.mul_en) begin
         prod_ff <= prod_in;
      end
      if (en.out_en) begin
         duty_ff <= duty_in;
      end
   end

   assign duty = duty_ff;

endmodule

// ===== design/tpsp_checker.sv =====
`timescale 1ns / 1ps

module tpsp_checker #(
   parameter int DUTY_FULL = tpsp_pkg::DUTY_FULL_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [tpsp_pkg::AMP_W-1:0]    req_amplitude,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [tpsp_pkg::DUTY_W-1:0]   rsp_duty_a,
   input logic [tpsp_pkg::DUTY_W-1:0]   rsp_duty_b,
   input logic [tpsp_pkg::DUTY_W-1:0]   rsp_duty_c
);

   localparam logic LIMIT_FITS = (2 * DUTY_FULL) < (1 << tpsp_pkg::DUTY_W);
   localparam logic [tpsp_pkg::DUTY_W-1:0] LIMIT = tpsp_pkg::DUTY_W'(2 * DUTY_FULL);

   logic       req_beat;
   logic       rsp_beat;
   logic [2:0] count_ff;
   logic [2:0] count_in;

   always_comb begin
      req_beat = req_valid && req_ready;
      rsp_beat = rsp_valid && rsp_ready;
      count_in = count_ff + 3'(req_beat) - 3'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // A held response beat keeps its values.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_a)
         && $stable(rsp_duty_b) && $stable(rsp_duty_c))
      else $error("response changed while stalled");

   // Requests are refused only while a response is held back.
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request refused with a free output");

   // Every response belongs to a request, and at most four are in flight.
   a_in_flight: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid |-> count_ff != 3'd0) && count_ff <= 3'd4)
      else $error("response count out of step with requests");

   a_limit: assert property (@(posedge clock) disable iff (reset)
      LIMIT_FITS && rsp_valid |-> rsp_duty_a <= LIMIT && rsp_duty_b <= LIMIT
         && rsp_duty_c <= LIMIT)
      else $error("duty above saturation limit");

   // Zero amplitude gives zero duty on its response when the output drains freely.
   a_zero_amp: assert property (@(posedge clock) disable iff (reset)
      req_beat && req_amplitude == '0 ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready
         |=> rsp_valid && rsp_duty_a == '0 && rsp_duty_b == '0 && rsp_duty_c == '0)
      else $error("zero amplitude gave non-zero duty");

endmodule

bind three_phase_sine_pwm_unit tpsp_checker #(
   .DUTY_FULL (DUTY_FULL)
) u_tpsp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_amplitude (req_bus.amplitude),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_duty_a    (rsp_bus.duty_a),
   .rsp_duty_b    (rsp_bus.duty_b),
   .rsp_duty_c    (rsp_bus.duty_c)
);
